// ===== rtl/adc_tws_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adc_tws_pkg
// Shared types and constants for the two-wire serial ADC master core.
// ----------------------------------------------------------------------------
package adc_tws_pkg;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_WAIT_S  = 4'd1,
		ST_RUN_S   = 4'd2,
		ST_WAIT_R  = 4'd3,
		ST_RUN_R   = 4'd4,
		ST_WAIT_W1 = 4'd5,
		ST_RUN_W1  = 4'd6,
		ST_WAIT_W2 = 4'd7,
		ST_RUN_W2  = 4'd8
	} seq_state_t;

	// Host actions
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_RDCFG = 2'd2,
		ACT_WRFLD = 2'd3
	} action_t;

	// Config field selectors
	localparam logic [7:0] FSEL_CHANNEL = 8'd0;
	localparam logic [7:0] FSEL_GAIN    = 8'd1;
	localparam logic [7:0] FSEL_RATE    = 8'd2;
	localparam logic [7:0] FSEL_REF     = 8'd3;

	// Device commands (7 bits on the wire)
	localparam logic [6:0] CMD_READ  = 7'h56;
	localparam logic [6:0] CMD_WRITE = 7'h65;

	// Field masks
	localparam logic [7:0] MASK_CHANNEL = 8'hFC;
	localparam logic [7:0] MASK_GAIN    = 8'hF3;
	localparam logic [7:0] MASK_RATE    = 8'hCF;
	localparam logic [7:0] MASK_REF     = 8'hBF;
	localparam logic [7:0] BIT_REF      = 8'h40;

	// Pulse numbers inside a run
	localparam logic [5:0] P_SAMPLE_BITS = 6'd24;
	localparam logic [5:0] P_SAMPLE_END  = 6'd26;
	localparam logic [5:0] P_PRE_CMD     = 6'd27;
	localparam logic [5:0] P_CMD_FIRST   = 6'd29;
	localparam logic [5:0] P_CMD_LAST    = 6'd35;
	localparam logic [5:0] P_CMD_HOLD    = 6'd36;
	localparam logic [5:0] P_DATA_FIRST  = 6'd37;
	localparam logic [5:0] P_DATA_LAST   = 6'd44;
	localparam logic [5:0] P_FINAL       = 6'd45;

endpackage : adc_tws_pkg
`default_nettype wire

// ===== rtl/adc_two_wire_serial_master_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adc_two_wire_serial_master_core
// Half-period tick sequencer for a 24-bit sigma-delta ADC with a shared
// DRDY/DOUT pin: sample reads, config reads and config field writes.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       to core    in_valid/in_stall   action, field_select, field_value,
//                                          dout_level
//  out      from core  out_valid/out_stall sck_level, sda_drive, sda_value,
//                                          busy_res, done_res, sample,
//                                          config_byte
//
// Every tick transaction gives one result, registered first in the input
// register and then in the result register; one tick per cycle is sustained
// while out is not stalled, with a single sequencer pass between the two.
// Reset clears the sequencer, counters and held words; no clearing pass.
// A stall on out holds the result register; in stalls only while the input
// register holds a tick behind a held result.
// ----------------------------------------------------------------------------
module adc_two_wire_serial_master_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             action,
	input  wire logic [7:0]             field_select,
	input  wire logic [7:0]             field_value,
	input  wire logic                   dout_level,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        sck_level,
	output logic                        sda_drive,
	output logic                        sda_value,
	output logic                        busy_res,
	output logic                        done_res,
	output logic signed [23:0]          sample,
	output logic [7:0]                  config_byte
);
	import adc_tws_pkg::*;

	// Field update for write-field commands
	function automatic logic [7:0] modify_byte(input logic [7:0] b,
		input logic [7:0] sel, input logic [7:0] v);
		logic [7:0] r;
		r = b;
		case (sel)
			FSEL_CHANNEL: begin
				r = b & MASK_CHANNEL;
				if (v == 8'd2 || v == 8'd3)
					r = r | {6'd0, v[1:0]};
			end
			FSEL_GAIN: begin
				r = b & MASK_GAIN;
				if (v inside {[8'd1:8'd3]})
					r = r | {4'd0, v[1:0], 2'd0};
			end
			FSEL_RATE: begin
				r = b & MASK_RATE;
				if (v inside {[8'd1:8'd3]})
					r = r | {2'd0, v[1:0], 4'd0};
			end
			FSEL_REF: begin
				if (v == 8'd0)
					r = b & MASK_REF;
				else if (v == 8'd1)
					r = b | BIT_REF;
			end
			default: r = b;
		endcase
		return r;
	endfunction

	// Input stage
	logic       valid_s1;
	logic [1:0] action_s1;
	logic [7:0] fsel_s1;
	logic [7:0] fval_s1;
	logic       dout_s1;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			fsel_s1   <= field_select;
			fval_s1   <= field_value;
			dout_s1   <= dout_level;
		end
	end

	// Sequencer state
	seq_state_t  state_q;
	logic [5:0]  pulse_q;
	logic        phase_q;
	logic [23:0] shift_q;
	logic [7:0]  config_q;
	logic [7:0]  pfield_q;
	logic [7:0]  pvalue_q;
	logic [23:0] sample_q;

	seq_state_t  state_d;
	logic [5:0]  pulse_d;
	logic        phase_d;
	logic [23:0] shift_d;
	logic [7:0]  config_d;
	logic [7:0]  pfield_d;
	logic [7:0]  pvalue_d;
	logic [23:0] sample_d;
	logic        done_d;

	logic        run;
	logic        high;
	logic        writing;
	logic        run_s;
	logic [6:0]  cmd;

	assign run     = (state_q == ST_RUN_S) || (state_q == ST_RUN_R) ||
	                 (state_q == ST_RUN_W1) || (state_q == ST_RUN_W2);
	assign high    = !phase_q;
	assign writing = (state_q == ST_RUN_W2);
	assign run_s   = (state_q == ST_RUN_S);
	assign cmd     = writing ? CMD_WRITE : CMD_READ;

	// Pin outputs for this tick
	logic sck_d, drv_d, val_d;

	always_comb begin
		sck_d = 1'b0;
		drv_d = 1'b0;
		val_d = 1'b0;
		if (run) begin
			sck_d = high;
			if (!run_s) begin
				if (pulse_q == P_PRE_CMD || pulse_q == (P_PRE_CMD + 6'd1)) begin
					drv_d = 1'b1;
				end else if (pulse_q >= P_CMD_FIRST && pulse_q <= P_CMD_LAST) begin
					drv_d = 1'b1;
					val_d = cmd[3'(P_CMD_LAST - pulse_q)];
				end else if (pulse_q == P_CMD_HOLD) begin
					drv_d = 1'b1;
					val_d = cmd[0];
				end else if (writing && pulse_q >= P_DATA_FIRST &&
				             pulse_q <= P_DATA_LAST) begin
					drv_d = 1'b1;
					val_d = config_q[3'(P_DATA_LAST - pulse_q)];
				end else if (writing && pulse_q == P_FINAL) begin
					drv_d = 1'b1;
					val_d = config_q[0];
				end
			end
		end
	end

	// Next state
	always_comb begin
		state_d  = state_q;
		pulse_d  = pulse_q;
		phase_d  = phase_q;
		shift_d  = shift_q;
		config_d = config_q;
		pfield_d = pfield_q;
		pvalue_d = pvalue_q;
		sample_d = sample_q;
		done_d   = 1'b0;
		case (state_q)
			ST_WAIT_S, ST_WAIT_R, ST_WAIT_W1, ST_WAIT_W2: begin
				if (!dout_s1) begin
					state_d = seq_state_t'(state_q + 4'd1);
					pulse_d = 6'd0;
					phase_d = 1'b0;
					shift_d = 24'd0;
				end
			end
			ST_RUN_S, ST_RUN_R, ST_RUN_W1, ST_RUN_W2: begin
				if (high) begin
					// config bits are taken on the high tick
					if (!writing && !run_s && pulse_q >= P_DATA_FIRST &&
					    pulse_q <= P_DATA_LAST)
						shift_d = {shift_q[22:0], dout_s1};
					phase_d = 1'b1;
				end else begin
					// sample bits are taken on the low tick
					if (pulse_q < P_SAMPLE_BITS)
						shift_d = {shift_q[22:0], dout_s1};
					phase_d = 1'b0;
					if (run_s && pulse_q >= P_SAMPLE_END) begin
						sample_d = shift_d;
						done_d   = 1'b1;
						state_d  = ST_IDLE;
					end else if (!run_s && pulse_q >= P_FINAL) begin
						if (state_q == ST_RUN_R) begin
							config_d = shift_d[7:0];
							done_d   = 1'b1;
							state_d  = ST_IDLE;
						end else if (state_q == ST_RUN_W1) begin
							config_d = modify_byte(shift_d[7:0], pfield_q, pvalue_q);
							state_d  = ST_WAIT_W2;
						end else begin
							done_d  = 1'b1;
							state_d = ST_IDLE;
						end
						pulse_d = 6'd0;
					end else begin
						pulse_d = pulse_q + 6'd1;
					end
				end
			end
			default: begin
				// idle, and any unused code
				state_d = ST_IDLE;
				if (action_s1 != ACT_TICK) begin
					pfield_d = fsel_s1;
					pvalue_d = fval_s1;
					case (action_s1)
						ACT_READ:  state_d = ST_WAIT_S;
						ACT_RDCFG: state_d = ST_WAIT_R;
						default:   state_d = ST_WAIT_W1;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pulse_q  <= 6'd0;
			phase_q  <= 1'b0;
			shift_q  <= 24'd0;
			config_q <= 8'd0;
			pfield_q <= 8'd0;
			pvalue_q <= 8'd0;
			sample_q <= 24'd0;
		end else if (advance) begin
			state_q  <= state_d;
			pulse_q  <= pulse_d;
			phase_q  <= phase_d;
			shift_q  <= shift_d;
			config_q <= config_d;
			pfield_q <= pfield_d;
			pvalue_q <= pvalue_d;
			sample_q <= sample_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sck_level   <= sck_d;
			sda_drive   <= drv_d;
			sda_value   <= val_d;
			busy_res    <= (state_d != ST_IDLE);
			done_res    <= done_d;
			sample      <= signed'(sample_d);
			config_byte <= config_d;
		end
	end

`ifndef SYNTH
	// A finished command never reports busy on the same tick
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && busy_res))
		else $error("done_res with busy_res");

	// Data level only when the pin is driven
	a_val_needs_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!sda_value || sda_drive))
		else $error("sda_value without sda_drive");

	// Input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	// Idle sequencer keeps the clock low
	a_idle_sck_low: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q == ST_IDLE) |=> !sck_level)
		else $error("sck high from idle");
`endif

endmodule : adc_two_wire_serial_master_core
`default_nettype wire

// ===== tb/tb_adc_two_wire_serial_master_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adc_two_wire_serial_master_core
// Self-checking bench for the two-wire serial ADC master core. Every tick
// transaction is run through a local model of the sequencer, and each result
// transaction is compared field by field with the oldest predicted pin
// state. Stimulus is whole ADC conversations (sample reads, config reads,
// field writes) with random ADC data, random waits for DRDY and random
// commands thrown in while busy. Random gaps are applied on in and random
// stalls on out.
// ----------------------------------------------------------------------------
module tb_adc_two_wire_serial_master_core;
	import adc_tws_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		action_t    act;
		logic [7:0] sel;
		logic [7:0] fval;
		logic       dout;
	} tick_t;

	typedef struct packed {
		logic        sck;
		logic        drv;
		logic        sdv;
		logic        busy;
		logic        done;
		logic [23:0] smp;
		logic [7:0]  cfg;
	} pins_t;

	logic clk;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = ACT_TICK;
	logic [7:0]  field_select = 8'd0;
	logic [7:0]  field_value = 8'd0;
	logic        dout_level = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        sck_level;
	logic        sda_drive;
	logic        sda_value;
	logic        busy_res;
	logic        done_res;
	logic signed [23:0] sample;
	logic [7:0]  config_byte;

	// Sequencer model state
	seq_state_t  mdl_state = ST_IDLE;
	logic [5:0]  mdl_pulse = 6'd0;
	logic        mdl_phase = 1'b0;
	logic [23:0] mdl_shift = 24'd0;
	logic [7:0]  mdl_config = 8'd0;
	logic [7:0]  mdl_sel = 8'd0;
	logic [7:0]  mdl_val = 8'd0;
	logic [23:0] mdl_sample = 24'd0;

	pins_t expected_pins_q[$];
	int    n_mismatch = 0;
	int    n_ticks = 0;
	int    quiet_cycles = 0;
	int    stall_left = 0;
	bit    calm = 1'b0;

	adc_two_wire_serial_master_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.field_select (field_select),
		.field_value  (field_value),
		.dout_level   (dout_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sck_level    (sck_level),
		.sda_drive    (sda_drive),
		.sda_value    (sda_value),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.sample       (sample),
		.config_byte  (config_byte)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Config byte after replacing one field
	function automatic logic [7:0] patch_config(input logic [7:0] b, input logic [7:0] sel,
		input logic [7:0] v);
		logic [7:0] r;
		r = b;
		case (sel)
			FSEL_CHANNEL: begin
				r &= MASK_CHANNEL;
				if (v == 8'd2 || v == 8'd3) r |= v;
			end
			FSEL_GAIN: begin
				r &= MASK_GAIN;
				if (v >= 8'd1 && v <= 8'd3) r |= {4'd0, v[1:0], 2'd0};
			end
			FSEL_RATE: begin
				r &= MASK_RATE;
				if (v >= 8'd1 && v <= 8'd3) r |= {2'd0, v[1:0], 4'd0};
			end
			FSEL_REF: begin
				if (v == 8'd0) r &= MASK_REF;
				else if (v == 8'd1) r |= BIT_REF;
			end
			default: ;
		endcase
		return r;
	endfunction

	// One half-period of the sequencer: pin levels and held words after the tick
	task automatic step_sequencer(input tick_t tk, output pins_t r);
		int         p;
		logic       hi;
		logic       wr;
		logic [6:0] cmd;
		r = '0;
		case (mdl_state)
			ST_IDLE: begin
				if (tk.act != ACT_TICK) begin
					mdl_sel = tk.sel;
					mdl_val = tk.fval;
					case (tk.act)
						ACT_READ:  mdl_state = ST_WAIT_S;
						ACT_RDCFG: mdl_state = ST_WAIT_R;
						default:   mdl_state = ST_WAIT_W1;
					endcase
				end
			end
			ST_WAIT_S, ST_WAIT_R, ST_WAIT_W1, ST_WAIT_W2: begin
				// DRDY low starts the pulse train on the next tick
				if (!tk.dout) begin
					case (mdl_state)
						ST_WAIT_S:  mdl_state = ST_RUN_S;
						ST_WAIT_R:  mdl_state = ST_RUN_R;
						ST_WAIT_W1: mdl_state = ST_RUN_W1;
						default:    mdl_state = ST_RUN_W2;
					endcase
					mdl_pulse = 6'd0;
					mdl_phase = 1'b0;
					mdl_shift = 24'd0;
				end
			end
			default: begin
				p   = int'(mdl_pulse);
				hi  = !mdl_phase;
				wr  = (mdl_state == ST_RUN_W2);
				cmd = wr ? CMD_WRITE : CMD_READ;
				r.sck = hi;
				// Data pin ownership: pre-command zeros, command, write data
				if (mdl_state != ST_RUN_S) begin
					if (p == P_PRE_CMD || p == P_PRE_CMD + 1) begin
						r.drv = 1'b1;
					end else if (p >= P_CMD_FIRST && p <= P_CMD_LAST) begin
						r.drv = 1'b1;
						r.sdv = cmd[P_CMD_LAST - p];
					end else if (p == P_CMD_HOLD) begin
						r.drv = 1'b1;
						r.sdv = cmd[0];
					end else if (wr && p >= P_DATA_FIRST && p <= P_DATA_LAST) begin
						r.drv = 1'b1;
						r.sdv = mdl_config[P_DATA_LAST - p];
					end else if (wr && p == P_FINAL) begin
						r.drv = 1'b1;
						r.sdv = mdl_config[0];
					end
				end
				if (hi) begin
					// config bits are taken on the high tick
					if (!wr && mdl_state != ST_RUN_S && p >= P_DATA_FIRST && p <= P_DATA_LAST)
						mdl_shift = {mdl_shift[22:0], tk.dout};
					mdl_phase = 1'b1;
				end else begin
					// sample bits on the low tick
					if (p < P_SAMPLE_BITS)
						mdl_shift = {mdl_shift[22:0], tk.dout};
					mdl_phase = 1'b0;
					if (mdl_state == ST_RUN_S && p >= P_SAMPLE_END) begin
						mdl_sample = mdl_shift;
						r.done = 1'b1;
						mdl_state = ST_IDLE;
					end else if (mdl_state != ST_RUN_S && p >= P_FINAL) begin
						if (mdl_state == ST_RUN_R) begin
							mdl_config = mdl_shift[7:0];
							r.done = 1'b1;
							mdl_state = ST_IDLE;
						end else if (mdl_state == ST_RUN_W1) begin
							mdl_config = patch_config(mdl_shift[7:0], mdl_sel, mdl_val);
							mdl_state = ST_WAIT_W2;
						end else begin
							r.done = 1'b1;
							mdl_state = ST_IDLE;
						end
						mdl_pulse = 6'd0;
					end else begin
						mdl_pulse = mdl_pulse + 6'd1;
					end
				end
			end
		endcase
		r.busy = (mdl_state != ST_IDLE);
		r.smp  = mdl_sample;
		r.cfg  = mdl_config;
	endtask

	// Result checking and prediction at each accepted transaction
	always @(posedge clk) begin
		pins_t got;
		pins_t exp_p;
		tick_t tk;
		if (out_valid === 1'b1 && out_stall == 1'b0) begin
			got = '{sck_level, sda_drive, sda_value, busy_res, done_res, sample, config_byte};
			if (expected_pins_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%0t: result with no tick pending: %p", $realtime, got);
			end else begin
				exp_p = expected_pins_q.pop_front();
				if (got !== exp_p) begin
					n_mismatch++;
					if (n_mismatch <= 10) begin
						$display("%0t: pin mismatch", $realtime);
						$display("  expected sck=%b drv=%b sda=%b busy=%b done=%b sample=%h cfg=%h",
							exp_p.sck, exp_p.drv, exp_p.sdv, exp_p.busy, exp_p.done,
							exp_p.smp, exp_p.cfg);
						$display("  actual   sck=%b drv=%b sda=%b busy=%b done=%b sample=%h cfg=%h",
							got.sck, got.drv, got.sdv, got.busy, got.done, got.smp, got.cfg);
					end
				end
			end
		end
		if (in_valid && in_stall === 1'b0) begin
			tk = '{action_t'(action), field_select, field_value, dout_level};
			step_sequencer(tk, exp_p);
			expected_pins_q.push_back(exp_p);
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Mostly short idle stretches, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 8);
		return $urandom_range(10, 30);
	endfunction

	function automatic int drdy_wait_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(9, 25);
	endfunction

	// Receiver stall generator
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (calm || $urandom_range(0, 99) < 75) begin
			out_stall <= 1'b0;
		end else begin
			stall_left <= gap_len() - 1;
			out_stall  <= 1'b1;
		end
	end

	// Send one tick transaction, returns at the edge it is accepted
	task automatic send_tick(input action_t a, input logic [7:0] s, input logic [7:0] v,
		input logic d);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 30) gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= a;
		field_select <= s;
		field_value  <= v;
		dout_level   <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_ticks++;
	endtask

	// Tick while busy: a random command that the core must ignore
	task automatic send_busy_tick(input logic d);
		send_tick(action_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), d);
	endtask

	// Wait for DRDY, then the full pulse train with ADC data on the pin
	task automatic clock_frame(input logic sample_only, input logic [23:0] word,
		input logic [7:0] cbyte, input int n_wait);
		int last;
		last = sample_only ? int'(P_SAMPLE_END) : int'(P_FINAL);
		repeat (n_wait) send_busy_tick(1'b1);
		send_busy_tick(1'b0);
		for (int p = 0; p <= last; p++) begin
			send_busy_tick((p >= P_DATA_FIRST && p <= P_DATA_LAST) ?
				cbyte[P_DATA_LAST - p] : 1'($urandom));
			send_busy_tick((p < P_SAMPLE_BITS) ? word[23 - p] : 1'($urandom));
		end
	endtask

	// One whole ADC conversation
	task automatic run_command(input action_t a, input logic [7:0] s, input logic [7:0] v,
		input logic [23:0] word, input logic [7:0] cbyte, input int wait_a, input int wait_b);
		send_tick(a, s, v, 1'($urandom));
		clock_frame(a == ACT_READ, word, cbyte, wait_a);
		if (a == ACT_WRFLD) clock_frame(1'b0, 24'($urandom), 8'($urandom), wait_b);
	endtask

	// Sign extremes of the conversion word
	task automatic test_sample_reads();
		logic [23:0] words[2];
		words = '{24'h7FFFFF, 24'h800000};
		foreach (words[i]) begin
			calm = (i == 0);
			run_command(ACT_READ, 8'($urandom), 8'($urandom), words[i], 8'($urandom), i % 3, 0);
		end
	endtask

	task automatic test_config_reads();
		logic [7:0] bytes_in[1];
		bytes_in = '{8'hA5};
		foreach (bytes_in[i]) begin
			calm = (i == 0);
			run_command(ACT_RDCFG, 8'($urandom), 8'($urandom), 24'($urandom), bytes_in[i],
				i * 2 + 1, 0);
		end
	endtask

	// Reserved channel code clears the field of a full byte
	task automatic test_field_writes();
		logic [7:0] sels[1];
		logic [7:0] vals[1];
		logic [7:0] cbyte;
		sels = '{FSEL_CHANNEL};
		vals = '{8'd1};
		foreach (sels[i]) begin
			calm = (i == 0);
			cbyte = (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'($urandom);
			run_command(ACT_WRFLD, sels[i], vals[i], 24'($urandom), cbyte, i % 4, (i + 1) % 3);
		end
	endtask

	// Random conversations with idle noise in between
	task automatic test_random_traffic();
		int         start;
		action_t    a;
		logic [7:0] s;
		logic [7:0] v;
		start = n_ticks;
		while (n_ticks - start < 60) begin
			calm = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					send_tick(ACT_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
			end else begin
				a = action_t'($urandom_range(1, 3));
				s = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
				v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
				run_command(a, s, v, 24'($urandom), 8'($urandom), drdy_wait_len(),
					drdy_wait_len());
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sample_reads();
		test_config_reads();
		test_field_writes();
		test_random_traffic();
		in_valid <= 1'b0;
		calm = 1'b1;
		// drain, then wait for anything stray
		while (expected_pins_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		n_mismatch += expected_pins_q.size();
		if (n_mismatch == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/adc_tws_pkg.sv
rtl/adc_two_wire_serial_master_core.sv
tb/tb_adc_two_wire_serial_master_core.sv
